[design/qrs_pkg.sv]
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ROOT_WIDTH     = 40;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_DISTINCT = 2'd0;
  localparam kind_t KIND_EQUAL    = 2'd1;
  localparam kind_t KIND_COMPLEX  = 2'd2;
  localparam kind_t KIND_INVALID  = 2'd3;

  localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = {1'b0, {(ROOT_WIDTH-1){1'b1}}};
  localparam logic [ROOT_WIDTH-1:0] ROOT_MIN = {1'b1, {(ROOT_WIDTH-1){1'b0}}};

  typedef struct packed {
    kind_t kind;
    logic  neg_one;
    logic  neg_two;
  } div_tag_t;

endpackage

[design/qrs_front.sv]
module qrs_front #(
  parameter int CW = qrs_pkg::COEF_WIDTH_DEF,
  parameter int F  = qrs_pkg::FRAC_BITS_DEF,
  localparam int MW  = 2*CW + 2,
  localparam int NBW = CW + 1 + F
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [CW-1:0]  coef_a,
  input  logic signed [CW-1:0]  coef_b,
  input  logic signed [CW-1:0]  coef_c,
  output logic                  out_valid,
  output logic [MW-1:0]         mag,
  output qrs_pkg::kind_t        kind,
  output logic signed [NBW-1:0] nb,
  output logic signed [CW-1:0]  a
);

  localparam int DSW = 2*CW + 3;

  logic                    v0_r, v1_r, v2_r;
  logic signed [CW-1:0]    a0_r, b0_r, c0_r, a1_r, b1_r, a2_r;
  logic signed [2*CW-1:0]  bb1_r, ac1_r;
  logic [MW-1:0]           mag2_r;
  qrs_pkg::kind_t          kind2_r;
  logic signed [NBW-1:0]   nb2_r;

  logic signed [DSW-1:0]   disc_nxt;
  logic [MW-1:0]           mag2_nxt;
  qrs_pkg::kind_t          kind2_nxt;
  logic signed [NBW-1:0]   nb2_nxt;

  always_comb begin
    disc_nxt = DSW'(bb1_r) - (DSW'(ac1_r) <<< 2);
    mag2_nxt = disc_nxt[DSW-1] ? MW'(-disc_nxt) : MW'(disc_nxt);
    nb2_nxt  = -(NBW'(b1_r) <<< F);
    if (a1_r == '0) begin
      kind2_nxt = qrs_pkg::KIND_INVALID;
    end else if (disc_nxt[DSW-1]) begin
      kind2_nxt = qrs_pkg::KIND_COMPLEX;
    end else if (disc_nxt == '0) begin
      kind2_nxt = qrs_pkg::KIND_EQUAL;
    end else begin
      kind2_nxt = qrs_pkg::KIND_DISTINCT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a0_r    <= coef_a;
    b0_r    <= coef_b;
    c0_r    <= coef_c;
    bb1_r   <= b0_r * b0_r;
    ac1_r   <= a0_r * c0_r;
    a1_r    <= a0_r;
    b1_r    <= b0_r;
    mag2_r  <= mag2_nxt;
    kind2_r <= kind2_nxt;
    nb2_r   <= nb2_nxt;
    a2_r    <= a1_r;
  end

  assign out_valid = v2_r;
  assign mag       = mag2_r;
  assign kind      = kind2_r;
  assign nb        = nb2_r;
  assign a         = a2_r;

endmodule

[design/qrs_sqrt.sv]
module qrs_sqrt #(
  parameter int MW  = 2*qrs_pkg::COEF_WIDTH_DEF + 2,
  parameter int F   = qrs_pkg::FRAC_BITS_DEF,
  parameter int SBW = 8,
  localparam int RW = (MW + 2*F) / 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [MW-1:0]  in_mag,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [RW-1:0]  out_root,
  output logic [SBW-1:0] out_sb
);

  localparam int RAW  = MW + 2*F;
  localparam int REMW = RW + 2;

  logic             v_r    [RW];
  logic [RAW-1:0]   rad_r  [RW];
  logic [REMW-1:0]  rem_r  [RW];
  logic [RW-1:0]    root_r [RW];
  logic [SBW-1:0]   sb_r   [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic            v_in;
    logic [RAW-1:0]  rad_in;
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [SBW-1:0]  sb_in;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = {in_mag, {(2*F){1'b0}}};
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sb_in   = sb_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_in[REMW-3:0], rad_in[RAW-1 -: 2]};
      trial  = {root_in, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[i]  <= rad_in << 2;
      rem_r[i]  <= ge ? rem_sh - trial : rem_sh;
      root_r[i] <= {root_in[RW-2:0], ge};
      sb_r[i]   <= sb_in;
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_sb    = sb_r[RW-1];

endmodule

[design/qrs_div.sv]
module qrs_div #(
  parameter int NW = qrs_pkg::COEF_WIDTH_DEF + qrs_pkg::FRAC_BITS_DEF + 2,
  parameter int DW = qrs_pkg::COEF_WIDTH_DEF + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num_one,
  input  logic [NW-1:0]     in_num_two,
  input  logic [DW-1:0]     in_den,
  input  qrs_pkg::div_tag_t in_tag,
  output logic              out_valid,
  output logic [NW-1:0]     out_quo_one,
  output logic [NW-1:0]     out_quo_two,
  output qrs_pkg::div_tag_t out_tag
);

  logic              v_r   [NW];
  logic [DW-1:0]     den_r [NW];
  qrs_pkg::div_tag_t tag_r [NW];
  logic [NW-1:0]     num_r [NW][2];
  logic [NW-1:0]     quo_r [NW][2];
  logic [DW-1:0]     rem_r [NW][2];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic              v_in;
    logic [DW-1:0]     den_in;
    qrs_pkg::div_tag_t tag_in;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      den_r[i] <= den_in;
      tag_r[i] <= tag_in;
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [NW-1:0] num_in;
      logic [NW-1:0] quo_in;
      logic [DW-1:0] rem_in;
      logic [DW:0]   rem_sh;
      logic [DW:0]   rem_sub;
      logic          ge;

      if (i == 0) begin : g_first
        assign num_in = (j == 0) ? in_num_one : in_num_two;
        assign quo_in = '0;
        assign rem_in = '0;
      end else begin : g_next
        assign num_in = num_r[i-1][j];
        assign quo_in = quo_r[i-1][j];
        assign rem_in = rem_r[i-1][j];
      end

      always_comb begin
        rem_sh  = {rem_in, num_in[NW-1]};
        ge      = rem_sh >= {1'b0, den_in};
        rem_sub = rem_sh - {1'b0, den_in};
      end

      always_ff @(posedge clk) begin
        num_r[i][j] <= num_in << 1;
        quo_r[i][j] <= {quo_in[NW-2:0], ge};
        rem_r[i][j] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      end
    end
  end

  assign out_valid   = v_r[NW-1];
  assign out_quo_one = quo_r[NW-1][0];
  assign out_quo_two = quo_r[NW-1][1];
  assign out_tag     = tag_r[NW-1];

endmodule

[design/quadratic_root_solver_unit.sv]
// pipeline: front end, bit-per-stage square root, numerator register, bit-per-stage divider
//   and output register
// throughput: one coefficient set per cycle, busy is always low
// reset: rst_n synchronous active low clears all stage valid bits, no result strobes after
// results cannot be stalled, out_valid strobes for exactly one cycle per item
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [COEF_WIDTH-1:0]           in_coef_a,
  input  logic signed [COEF_WIDTH-1:0]           in_coef_b,
  input  logic signed [COEF_WIDTH-1:0]           in_coef_c,
  output logic                                   out_valid,
  output logic [1:0]                             out_root_kind,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  out_root_one,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  out_root_two
);

  localparam int CW   = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int RTW  = qrs_pkg::ROOT_WIDTH;
  localparam int MW   = 2*CW + 2;
  localparam int NBW  = CW + 1 + F;
  localparam int RW   = CW + 1 + F;
  localparam int SBW  = 2 + NBW + CW;
  localparam int NSW  = CW + F + 3;
  localparam int MGW  = NSW - 1;
  localparam int DW   = CW + 1;
  localparam int LW   = ((MGW > RTW) ? MGW : RTW) + 1;
  localparam int LATENCY = 3 + RW + 1 + MGW + 1;

  // front end
  logic                  f_valid;
  logic [MW-1:0]         f_mag;
  qrs_pkg::kind_t        f_kind;
  logic signed [NBW-1:0] f_nb;
  logic signed [CW-1:0]  f_a;

  qrs_front #(.CW(CW), .F(F)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .coef_a    (in_coef_a),
    .coef_b    (in_coef_b),
    .coef_c    (in_coef_c),
    .out_valid (f_valid),
    .mag       (f_mag),
    .kind      (f_kind),
    .nb        (f_nb),
    .a         (f_a)
  );

  // square root
  logic           s_valid;
  logic [RW-1:0]  s_root;
  logic [SBW-1:0] s_sb;

  qrs_sqrt #(.MW(MW), .F(F), .SBW(SBW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_mag    (f_mag),
    .in_sb     ({f_kind, f_nb, f_a}),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_sb    (s_sb)
  );

  // numerator stage
  qrs_pkg::kind_t        s_kind;
  logic signed [NBW-1:0] s_nb;
  logic signed [CW-1:0]  s_a;
  logic signed [NSW-1:0] s_x, nb_x, num_one, num_two;
  logic [DW-1:0]         amag;
  qrs_pkg::div_tag_t     tag_nxt;

  logic                  nv_r;
  logic [MGW-1:0]        nmag_one_r, nmag_two_r;
  logic [DW-1:0]         nden_r;
  qrs_pkg::div_tag_t     ntag_r;

  always_comb begin
    {s_kind, s_nb, s_a} = s_sb;
    s_x  = signed'(NSW'(s_root));
    nb_x = NSW'(s_nb);
    if (s_kind == qrs_pkg::KIND_COMPLEX) begin
      num_one = nb_x;
      num_two = s_x;
    end else begin
      num_one = nb_x + s_x;
      num_two = nb_x - s_x;
    end
    amag            = s_a[CW-1] ? -DW'(s_a) : DW'(s_a);
    tag_nxt.kind    = s_kind;
    tag_nxt.neg_one = num_one[NSW-1] ^ s_a[CW-1];
    tag_nxt.neg_two = num_two[NSW-1] ^ s_a[CW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else begin
      nv_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    nmag_one_r <= num_one[NSW-1] ? MGW'(-num_one) : MGW'(num_one);
    nmag_two_r <= num_two[NSW-1] ? MGW'(-num_two) : MGW'(num_two);
    nden_r     <= {amag[DW-2:0], 1'b0};
    ntag_r     <= tag_nxt;
  end

  // division
  logic              d_valid;
  logic [MGW-1:0]    d_quo_one, d_quo_two;
  qrs_pkg::div_tag_t d_tag;

  qrs_div #(.NW(MGW), .DW(DW)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (nv_r),
    .in_num_one  (nmag_one_r),
    .in_num_two  (nmag_two_r),
    .in_den      (nden_r),
    .in_tag      (ntag_r),
    .out_valid   (d_valid),
    .out_quo_one (d_quo_one),
    .out_quo_two (d_quo_two),
    .out_tag     (d_tag)
  );

  // sign and saturation
  function automatic logic [RTW-1:0] sat_root(input logic [MGW-1:0] q, input logic neg);
    logic [LW-1:0] qx;
    logic [LW-1:0] lim;
    qx  = LW'(q);
    lim = LW'(1) << (RTW - 1);
    if (neg) begin
      sat_root = (qx > lim) ? qrs_pkg::ROOT_MIN : RTW'(-qx);
    end else begin
      sat_root = (qx >= lim) ? qrs_pkg::ROOT_MAX : RTW'(qx);
    end
  endfunction

  logic           out_valid_r;
  qrs_pkg::kind_t kind_r;
  logic [RTW-1:0] root_one_r, root_two_r;
  logic [RTW-1:0] root_one_nxt, root_two_nxt;

  always_comb begin
    if (d_tag.kind == qrs_pkg::KIND_INVALID) begin
      root_one_nxt = '0;
      root_two_nxt = '0;
    end else begin
      root_one_nxt = sat_root(d_quo_one, d_tag.neg_one);
      root_two_nxt = sat_root(d_quo_two, d_tag.neg_two);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= d_tag.kind;
    root_one_r <= root_one_nxt;
    root_two_r <= root_two_nxt;
  end

  assign busy          = 1'b0;
  assign out_valid     = out_valid_r;
  assign out_root_kind = kind_r;
  assign out_root_one  = signed'(root_one_r);
  assign out_root_two  = signed'(root_two_r);

endmodule

[design/qrs_checker.sv]
module qrs_checker #(
  parameter int LATENCY = 72
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic [1:0]                            out_root_kind,
  input logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_one,
  input logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_two
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_result_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result beat without matching start");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_root_kind == qrs_pkg::KIND_INVALID) |->
      (out_root_one == '0 && out_root_two == '0))
    else $error("invalid kind with nonzero roots");

  a_equal_roots: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_root_kind == qrs_pkg::KIND_EQUAL) |-> out_root_one == out_root_two)
    else $error("equal kind with different roots");

endmodule

bind quadratic_root_solver_unit qrs_checker #(.LATENCY(LATENCY)) u_qrs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_root_kind (out_root_kind),
  .out_root_one  (out_root_one),
  .out_root_two  (out_root_two)
);

[tb/quadratic_root_solver_unit_tb.sv]
module quadratic_root_solver_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = qrs_pkg::COEF_WIDTH_DEF;
  localparam int FB = qrs_pkg::FRAC_BITS_DEF;
  localparam int RTW = qrs_pkg::ROOT_WIDTH;
  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coef_set_t;

  typedef struct {
    qrs_pkg::kind_t kind;
    logic signed [RTW-1:0] one;
    logic signed [RTW-1:0] two;
  } roots_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_coef_a = '0;
  logic signed [CW-1:0] in_coef_b = '0;
  logic signed [CW-1:0] in_coef_c = '0;
  logic out_valid;
  logic [1:0] out_root_kind;
  logic signed [RTW-1:0] out_root_one;
  logic signed [RTW-1:0] out_root_two;

  coef_set_t pending_sets[$];
  roots_t expected_roots[$];
  int errors = 0;
  int cycle_count = 0;
  int gap_left = 0;
  bit gaps_on = 1'b1;
  bit hold_for_drain = 1'b0;

  quadratic_root_solver_unit dut (.*);

  always #6 clk = ~clk;

  function automatic logic [63:0] scaled_sqrt(input logic [63:0] mag);
    logic [127:0] wide;
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    wide = {64'd0, mag} << (2 * FB);
    rem = '0;
    root = '0;
    for (int p = 126; p >= 0; p -= 2) begin
      rem = (rem << 2) | wide[p+:2];
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic signed [RTW-1:0] clamp_root(input longint v);
    if (v > longint'(qrs_pkg::ROOT_MAX)) return qrs_pkg::ROOT_MAX;
    if (v < -(longint'(1) <<< (RTW - 1))) return qrs_pkg::ROOT_MIN;
    return v[RTW-1:0];
  endfunction

  function automatic roots_t solve_roots(input coef_set_t cs);
    roots_t r;
    longint a, b, c, disc, s, den, nb;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_INVALID;
      r.one = '0;
      r.two = '0;
      return r;
    end
    disc = b * b - 4 * a * c;
    s = longint'(scaled_sqrt(disc < 0 ? -disc : disc));
    den = 2 * a;
    nb = -b * (longint'(1) <<< FB);
    if (disc > 0) begin
      r.kind = qrs_pkg::KIND_DISTINCT;
      r.one = clamp_root((nb + s) / den);
      r.two = clamp_root((nb - s) / den);
    end else if (disc == 0) begin
      r.kind = qrs_pkg::KIND_EQUAL;
      r.one = clamp_root(nb / den);
      r.two = r.one;
    end else begin
      r.kind = qrs_pkg::KIND_COMPLEX;
      r.one = clamp_root(nb / den);
      r.two = clamp_root(s / den);
    end
    return r;
  endfunction

  function automatic coef_set_t make_set(input int a, input int b, input int c);
    coef_set_t cs;
    cs.a = a[CW-1:0];
    cs.b = b[CW-1:0];
    cs.c = c[CW-1:0];
    return cs;
  endfunction

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 7) - 3);
      1: return CW'({1'b1, {(CW-1){1'b0}}} + $urandom_range(0, 3));
      2: return CW'({1'b0, {(CW-1){1'b1}}} - $urandom_range(0, 3));
      3: return CW'($urandom_range(0, 255) - 128);
      default: return CW'($urandom);
    endcase
  endfunction

  // driver: a beat moves at each edge with start high and busy low
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) begin
        coef_set_t cs;
        cs = pending_sets.pop_front();
        expected_roots.push_back(solve_roots(cs));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (hold_for_drain && expected_roots.size() != 0) begin
        start <= 1'b0;
      end else if (pending_sets.size() > 0) begin
        if (gaps_on && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 7);
          start <= 1'b0;
        end else begin
          coef_set_t nx;
          nx = pending_sets[0];
          start <= 1'b1;
          in_coef_a <= nx.a;
          in_coef_b <= nx.b;
          in_coef_c <= nx.c;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected beat kind=%0d", out_root_kind);
        errors++;
      end else begin
        roots_t ex;
        ex = expected_roots.pop_front();
        if (out_root_kind !== ex.kind) begin
          $error("root_kind exp %0d got %0d", ex.kind, out_root_kind);
          errors++;
        end
        if (out_root_one !== ex.one) begin
          $error("root_one exp %0d got %0d", ex.one, out_root_one);
          errors++;
        end
        if (out_root_two !== ex.two) begin
          $error("root_two exp %0d got %0d", ex.two, out_root_two);
          errors++;
        end
      end
    end
  end

  initial begin
    int lo, hi;
    lo = -(1 << (CW - 1));
    hi = (1 << (CW - 1)) - 1;
    pending_sets.push_back(make_set(0, 5, 7));
    pending_sets.push_back(make_set(0, 0, 0));
    pending_sets.push_back(make_set(1, -3, 2));
    pending_sets.push_back(make_set(1, 2, 1));
    pending_sets.push_back(make_set(1, 0, 1));
    pending_sets.push_back(make_set(-1, 0, 1));
    pending_sets.push_back(make_set(-1, 0, -1));
    pending_sets.push_back(make_set(2, 0, 0));
    pending_sets.push_back(make_set(lo, lo, lo));
    pending_sets.push_back(make_set(hi, hi, hi));
    pending_sets.push_back(make_set(lo, hi, lo));
    pending_sets.push_back(make_set(hi, lo, hi));
    pending_sets.push_back(make_set(hi, lo, lo));
    pending_sets.push_back(make_set(lo, lo, hi));
    pending_sets.push_back(make_set(1, lo, 0));
    pending_sets.push_back(make_set(-1, hi, 0));
    pending_sets.push_back(make_set(1, hi, lo));
    pending_sets.push_back(make_set(-1, -1, -1));
    pending_sets.push_back(make_set(3, 7, -11));
    pending_sets.push_back(make_set(-2, 4, -2));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_sets.size() == 0);
    hold_for_drain = 1'b1;
    wait (expected_roots.size() == 0);
    hold_for_drain = 1'b0;
    for (int i = 0; i < 1000; i++) begin
      coef_set_t cs;
      int k;
      cs.a = rand_coef();
      cs.b = rand_coef();
      cs.c = rand_coef();
      // perfect squares hit the equal-root case
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, 180) - 90;
        cs.a = CW'(1);
        cs.b = CW'(2 * k);
        cs.c = CW'(k * k);
      end
      pending_sets.push_back(cs);
    end
    wait (pending_sets.size() < 150);
    gaps_on = 1'b0;
    wait (pending_sets.size() == 0);
    wait (expected_roots.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count >= MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
